### src/btss_pkg.sv
// Shared types and constants for the BER TLV stream scanner.
// No dependencies.
`default_nettype none
package btss_pkg;
    localparam logic [7:0] INT_TAG    = 8'h02;
    localparam logic [7:0] FILTER_AND = 8'hA0;
    localparam logic [7:0] FILTER_SUB = 8'hA4;
    localparam logic [2:0] KIND_OTHER = 3'd5;
    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_LENGTH = 2'd1;
    localparam logic [1:0] ERR_INTLEN = 2'd2;
    localparam logic [1:0] ERR_TRUNC  = 2'd3;

    typedef struct packed {
        logic [7:0]  tag_value;
        logic [31:0] content_length;
        logic [7:0]  header_bytes;
        logic        entered;
        logic        integer_valid;
        logic [31:0] integer_value;
        logic [2:0]  filter_kind;
        logic [1:0]  error_code;
    } t_result;

    function automatic logic [2:0] kind_of(input logic [7:0] t);
        if (t >= FILTER_AND && t <= FILTER_SUB) begin
            kind_of = 3'(t - FILTER_AND);
        end else begin
            kind_of = KIND_OTHER;
        end
    endfunction
endpackage
`default_nettype wire

### src/ber_tlv_stream_scanner_top.sv
// Top level of the BER TLV stream scanner: decoder front and result queue.
// Depends on btss_pkg, btss_front and btss_queue.
`default_nettype none
// The scanner takes one stream byte per cycle and reports at most one result per
// TLV: at the end of the header when the descend flag on the tag byte is set or
// the length is zero, after the last value byte otherwise, or early on an error.
// A byte is decoded in the cycle it is accepted, and its result enters a two-entry
// queue, so the sustained rate is one byte per cycle; the input stalls only when
// the queue is full and the consumer is not taking results.
module ber_tlv_stream_scanner_top import btss_pkg::*; #(
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_descend,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_tag_value,
    output logic [31:0]      o_content_length,
    output logic [7:0]       o_header_bytes,
    output logic             o_entered,
    output logic             o_integer_valid,
    output logic [31:0]      o_integer_value,
    output logic [2:0]       o_filter_kind,
    output logic [1:0]       o_error_code
);
    t_result res, qout;
    logic    res_valid, full, accept;

    // A full queue still takes an item when the consumer drains one this cycle.
    assign o_ready = !full || i_ready;
    assign accept  = i_valid && o_ready;

    btss_front #(.MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(accept),
        .i_data_byte(i_data_byte), .i_descend(i_descend), .i_last_byte(i_last_byte),
        .o_res(res), .o_res_valid(res_valid)
    );

    btss_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(accept && res_valid), .i_data(res),
        .o_full(full), .o_valid(o_valid), .i_rd(o_valid && i_ready), .o_data(qout)
    );

    assign o_tag_value      = qout.tag_value;
    assign o_content_length = qout.content_length;
    assign o_header_bytes   = qout.header_bytes;
    assign o_entered        = qout.entered;
    assign o_integer_valid  = qout.integer_valid;
    assign o_integer_value  = qout.integer_value;
    assign o_filter_kind    = qout.filter_kind;
    assign o_error_code     = qout.error_code;
endmodule
`default_nettype wire

### src/btss_front.sv
// Front part: accepts stream bytes and runs the TLV decode, one byte per cycle while i_en is high.
// Depends on btss_pkg.
`default_nettype none
module btss_front import btss_pkg::*; #(
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_descend,
    input  wire logic       i_last_byte,
    output t_result         o_res,
    output logic            o_res_valid
);
    localparam logic [2:0] PH_TAG = 3'd0, PH_LEN_FIRST = 3'd1, PH_LEN_LONG = 3'd2,
                           PH_VALUE = 3'd3;
    localparam logic [6:0] LIMIT = 7'((MAX_LENGTH_BYTES < 4) ? MAX_LENGTH_BYTES : 4);

    logic [2:0]  r_phase, n_phase;
    logic [7:0]  r_tag, n_tag;
    logic [31:0] r_len, n_len;
    logic [6:0]  r_left, n_left;
    logic [7:0]  r_hdr, n_hdr;
    logic [31:0] r_vleft, n_vleft;
    logic [31:0] r_iacc, n_iacc;
    logic        r_dsc, n_dsc;

    always_comb begin
        logic        fin;
        logic [31:0] flen;
        n_phase = r_phase; n_tag = r_tag; n_len = r_len; n_left = r_left;
        n_hdr = r_hdr; n_vleft = r_vleft; n_iacc = r_iacc; n_dsc = r_dsc;
        o_res_valid = 1'b0;
        o_res = '0;
        fin = 1'b0;
        flen = '0;
        unique case (r_phase)
            PH_TAG: begin
                n_tag = i_data_byte; n_dsc = i_descend; n_hdr = 8'd1;
                n_len = '0; n_iacc = '0; n_vleft = '0; n_left = '0;
                n_phase = PH_LEN_FIRST;
                if (i_last_byte) begin
                    o_res_valid = 1'b1; o_res.error_code = ERR_TRUNC;
                end
            end
            PH_LEN_FIRST: begin
                n_hdr = 8'd2;
                if (!i_data_byte[7]) begin
                    fin = 1'b1; flen = {24'd0, i_data_byte};
                end else begin
                    n_left = i_data_byte[6:0];
                    n_len = '0;
                    if (i_data_byte[6:0] == 7'd0) begin
                        fin = 1'b1;
                    end else begin
                        n_phase = PH_LEN_LONG;
                        if (i_last_byte) begin
                            o_res_valid = 1'b1; o_res.error_code = ERR_TRUNC;
                        end
                    end
                end
            end
            PH_LEN_LONG: begin
                n_hdr = r_hdr + 8'd1;
                if (r_left > LIMIT && i_data_byte != 8'h00) begin
                    o_res_valid = 1'b1; o_res.error_code = ERR_LENGTH;
                end else begin
                    n_len = {r_len[23:0], i_data_byte};
                    n_left = r_left - 7'd1;
                    if (n_left == 7'd0) begin
                        fin = 1'b1; flen = n_len;
                    end else if (i_last_byte) begin
                        o_res_valid = 1'b1; o_res.error_code = ERR_TRUNC;
                    end
                end
            end
            PH_VALUE: begin
                n_iacc = {r_iacc[23:0], i_data_byte};
                n_vleft = r_vleft - 32'd1;
                o_res.content_length = r_len;
                if (n_vleft == 32'd0) begin
                    o_res_valid = 1'b1;
                    if (r_tag == INT_TAG) begin
                        if (r_len <= 32'd4) begin
                            o_res.integer_valid = 1'b1; o_res.integer_value = n_iacc;
                        end else begin
                            o_res.error_code = ERR_INTLEN;
                        end
                    end
                end else if (i_last_byte) begin
                    o_res_valid = 1'b1; o_res.error_code = ERR_TRUNC;
                end
            end
            default: n_phase = PH_TAG;
        endcase
        if (fin) begin
            n_len = flen;
            if (r_dsc) begin
                o_res_valid = 1'b1; o_res.entered = 1'b1; o_res.content_length = flen;
                o_res.error_code = (i_last_byte && flen != 0) ? ERR_TRUNC : ERR_OK;
            end else if (flen == 0) begin
                o_res_valid = 1'b1;
                o_res.error_code = (r_tag == INT_TAG) ? ERR_INTLEN : ERR_OK;
            end else if (i_last_byte) begin
                o_res_valid = 1'b1; o_res.content_length = flen; o_res.error_code = ERR_TRUNC;
            end else begin
                n_vleft = flen; n_iacc = '0; n_phase = PH_VALUE;
            end
        end
        o_res.tag_value = n_tag;
        o_res.header_bytes = n_hdr;
        o_res.filter_kind = kind_of(n_tag);
        if (o_res_valid) n_phase = PH_TAG;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TAG; r_tag <= '0; r_len <= '0; r_left <= '0;
            r_hdr <= '0; r_vleft <= '0; r_iacc <= '0; r_dsc <= 1'b0;
        end else if (i_en) begin
            r_phase <= n_phase; r_tag <= n_tag; r_len <= n_len; r_left <= n_left;
            r_hdr <= n_hdr; r_vleft <= n_vleft; r_iacc <= n_iacc; r_dsc <= n_dsc;
        end
    end

`ifndef SYNTHESIS
    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_VALUE) else $error("phase out of range");
    a_value_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_VALUE |-> r_vleft != 0) else $error("value count zero");
    a_long_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_LEN_LONG |-> r_left != 0) else $error("length count zero");
`endif
endmodule
`default_nettype wire

### src/btss_queue.sv
// Two-entry result queue between the decoder and the output port.
// Depends on btss_pkg.
`default_nettype none
module btss_queue import btss_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_wr,
    input  wire t_result i_data,
    output logic         o_full,
    output logic         o_valid,
    input  wire logic    i_rd,
    output t_result      o_data
);
    t_result    r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_wr) r_wp <= ~r_wp;
            if (i_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_wr) - 2'(i_rd);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_wr || i_rd) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> o_valid) else $error("queue underflow");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count invalid");
`endif
endmodule
`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the BER TLV stream scanner.
// Depends on btss_pkg and ber_tlv_stream_scanner_top; holds its own TLV predictor.
`default_nettype none
module testbench;
    import btss_pkg::*;

    localparam int LEN_LIMIT = 4;

    typedef enum logic [1:0] {
        SCAN_TAG, SCAN_LEN_FIRST, SCAN_LEN_LONG, SCAN_VALUE
    } t_scan_phase;

    // Scoreboard: tracks the scanner state the way the block should, and queues the
    // result each accepted byte is expected to produce.
    class tlv_scoreboard;
        t_scan_phase phase;
        logic [7:0]  cur_tag;
        logic [31:0] len_acc;
        logic [6:0]  len_left;
        logic [7:0]  hdr_count;
        logic [31:0] value_left;
        logic [31:0] int_acc;
        logic        dive;
        t_result     pending_results[$];
        int          errors;

        function void clear();
            phase = SCAN_TAG;
            cur_tag = 8'h00;
            len_acc = '0;
            len_left = '0;
            hdr_count = '0;
            value_left = '0;
            int_acc = '0;
            dive = 1'b0;
            pending_results.delete();
            errors = 0;
        endfunction

        function logic [2:0] filter_of(logic [7:0] t);
            if (t >= FILTER_AND && t <= FILTER_SUB) begin
                return t[2:0];
            end
            return KIND_OTHER;
        endfunction

        function void report(logic [31:0] len, logic ent, logic iv, logic [31:0] ival,
                             logic [1:0] err);
            t_result r;
            r.tag_value = cur_tag;
            r.content_length = len;
            r.header_bytes = hdr_count;
            r.entered = ent;
            r.integer_valid = iv;
            r.integer_value = ival;
            r.filter_kind = filter_of(cur_tag);
            r.error_code = err;
            pending_results = {pending_results, r};
            phase = SCAN_TAG;
        endfunction

        function void header_done(logic [31:0] len, logic last);
            len_acc = len;
            if (dive) begin
                report(len, 1'b1, 1'b0, '0, (last && len != 0) ? ERR_TRUNC : ERR_OK);
            end else if (len == 0) begin
                report('0, 1'b0, 1'b0, '0, (cur_tag == INT_TAG) ? ERR_INTLEN : ERR_OK);
            end else if (last) begin
                report(len, 1'b0, 1'b0, '0, ERR_TRUNC);
            end else begin
                value_left = len;
                int_acc = '0;
                phase = SCAN_VALUE;
            end
        endfunction

        // Note one accepted input byte.
        function void take_byte(logic [7:0] b, logic dsc, logic last);
            case (phase)
                SCAN_TAG: begin
                    cur_tag = b;
                    dive = dsc;
                    hdr_count = 8'd1;
                    len_acc = '0;
                    int_acc = '0;
                    value_left = '0;
                    len_left = '0;
                    phase = SCAN_LEN_FIRST;
                    if (last) report('0, 1'b0, 1'b0, '0, ERR_TRUNC);
                end
                SCAN_LEN_FIRST: begin
                    hdr_count = 8'd2;
                    if (!b[7]) begin
                        header_done({24'd0, b}, last);
                    end else begin
                        len_left = b[6:0];
                        len_acc = '0;
                        if (len_left == 0) begin
                            header_done('0, last);
                        end else begin
                            phase = SCAN_LEN_LONG;
                            if (last) report('0, 1'b0, 1'b0, '0, ERR_TRUNC);
                        end
                    end
                end
                SCAN_LEN_LONG: begin
                    hdr_count = hdr_count + 8'd1;
                    if (len_left > LEN_LIMIT && b != 0) begin
                        report('0, 1'b0, 1'b0, '0, ERR_LENGTH);
                    end else begin
                        len_acc = {len_acc[23:0], b};
                        len_left = len_left - 7'd1;
                        if (len_left == 0) begin
                            header_done(len_acc, last);
                        end else if (last) begin
                            report('0, 1'b0, 1'b0, '0, ERR_TRUNC);
                        end
                    end
                end
                default: begin
                    int_acc = {int_acc[23:0], b};
                    value_left = value_left - 32'd1;
                    if (value_left == 0) begin
                        if (cur_tag == INT_TAG && len_acc <= 4) begin
                            report(len_acc, 1'b0, 1'b1, int_acc, ERR_OK);
                        end else if (cur_tag == INT_TAG) begin
                            report(len_acc, 1'b0, 1'b0, '0, ERR_INTLEN);
                        end else begin
                            report(len_acc, 1'b0, 1'b0, '0, ERR_OK);
                        end
                    end else if (last) begin
                        report(len_acc, 1'b0, 1'b0, '0, ERR_TRUNC);
                    end
                end
            endcase
        endfunction

        // Compare one accepted result with the oldest expectation.
        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.tag_value !== want.tag_value) begin
                $display("%0t: tag_value expected %h actual %h", $time,
                         want.tag_value, got.tag_value);
                errors++;
            end
            if (got.content_length !== want.content_length) begin
                $display("%0t: content_length expected %h actual %h", $time,
                         want.content_length, got.content_length);
                errors++;
            end
            if (got.header_bytes !== want.header_bytes) begin
                $display("%0t: header_bytes expected %0d actual %0d", $time,
                         want.header_bytes, got.header_bytes);
                errors++;
            end
            if (got.entered !== want.entered) begin
                $display("%0t: entered expected %b actual %b", $time,
                         want.entered, got.entered);
                errors++;
            end
            if (got.integer_valid !== want.integer_valid) begin
                $display("%0t: integer_valid expected %b actual %b", $time,
                         want.integer_valid, got.integer_valid);
                errors++;
            end
            if (got.integer_value !== want.integer_value) begin
                $display("%0t: integer_value expected %h actual %h", $time,
                         want.integer_value, got.integer_value);
                errors++;
            end
            if (got.filter_kind !== want.filter_kind) begin
                $display("%0t: filter_kind expected %0d actual %0d", $time,
                         want.filter_kind, got.filter_kind);
                errors++;
            end
            if (got.error_code !== want.error_code) begin
                $display("%0t: error_code expected %0d actual %0d", $time,
                         want.error_code, got.error_code);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_descend;
    logic        i_last_byte;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_tag_value;
    logic [31:0] o_content_length;
    logic [7:0]  o_header_bytes;
    logic        o_entered;
    logic        o_integer_valid;
    logic [31:0] o_integer_value;
    logic [2:0]  o_filter_kind;
    logic [1:0]  o_error_code;

    ber_tlv_stream_scanner_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_data_byte(i_data_byte), .i_descend(i_descend), .i_last_byte(i_last_byte),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_tag_value(o_tag_value), .o_content_length(o_content_length),
        .o_header_bytes(o_header_bytes), .o_entered(o_entered),
        .o_integer_valid(o_integer_valid), .o_integer_value(o_integer_value),
        .o_filter_kind(o_filter_kind), .o_error_code(o_error_code)
    );

    tlv_scoreboard sb;

    // Idle percentages per side; the stimulus process changes them by phase.
    int sender_idle_pct;
    int receiver_idle_pct;
    // When set, the receiver holds i_ready low for this many cycles.
    int hold_off_cycles;
    int bytes_sent;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // The run must never get close to this; it only guards against a hang.
    initial begin
        #(12 * 400000);
        $display("*** FAILED ***");
        $finish;
    end

    // Scoreboard check of every accepted byte and result, sampled at the edge.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                sb.take_byte(i_data_byte, i_descend, i_last_byte);
            end
            if (o_valid && i_ready) begin
                got.tag_value = o_tag_value;
                got.content_length = o_content_length;
                got.header_bytes = o_header_bytes;
                got.entered = o_entered;
                got.integer_valid = o_integer_valid;
                got.integer_value = o_integer_value;
                got.filter_kind = o_filter_kind;
                got.error_code = o_error_code;
                sb.check_result(got);
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off counted here on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Offer one byte, with a random gap first, and wait until it is accepted.
    task automatic send_byte(input logic [7:0] b, input logic dsc, input logic last);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_descend <= dsc;
        i_last_byte <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Send one TLV: tag, length octets and value. Value bytes are only generated
    // for skipped TLVs. A random last_byte placement exercises truncation.
    task automatic send_tlv(input logic [7:0] tag, input logic dsc, input int len,
                            input int len_octets, input bit trunc);
        logic [7:0] hdr[$];
        int total;
        int cut;
        int i;
        hdr = {hdr, tag};
        if (len_octets == 0) begin
            hdr = {hdr, 8'(len)};
        end else begin
            hdr = {hdr, 8'h80 | 8'(len_octets)};
            for (i = len_octets - 1; i >= 0; i--) begin
                hdr = {hdr, (i < 4) ? 8'(len >> (8 * i)) : 8'h00};
            end
        end
        if (!dsc) begin
            for (i = 0; i < len; i++) hdr = {hdr, 8'($urandom)};
        end
        total = hdr.size();
        cut = trunc ? $urandom_range(total - 1) : -1;
        for (i = 0; i < total; i++) begin
            // The descend flag matters only on the tag; elsewhere it is random.
            send_byte(hdr[i], (i == 0) ? dsc : 1'($urandom),
                      (i == cut) || (i == total - 1 && $urandom_range(9) == 0));
            if (i == cut) break;
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_tlv();
        logic [7:0] tag;
        int sel;
        int len;
        int octs;
        sel = $urandom_range(9);
        case (sel)
            0, 1, 2: tag = INT_TAG;
            3, 4, 5: tag = 8'($urandom_range(8'hA4, 8'hA0));
            default: tag = 8'($urandom);
        endcase
        len = (tag == INT_TAG) ? $urandom_range(6) : $urandom_range(12);
        octs = ($urandom_range(3) == 0) ? $urandom_range(6) : 0;
        // Lengths stay at most 12, so every long form, one octet included,
        // carries the value directly.
        send_tlv(tag, ($urandom_range(3) == 0), len, octs, ($urandom_range(9) == 0));
    endtask

    initial begin
        int k;
        sb = new();
        sb.clear();
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        hold_off_cycles = 0;
        bytes_sent = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data_byte = 8'h00;
        i_descend = 1'b0;
        i_last_byte = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: integers of several lengths, length forms, filters, errors.
        sender_idle_pct = 16;
        receiver_idle_pct = 46;
        send_tlv(INT_TAG, 1'b0, 1, 0, 0);
        send_byte(INT_TAG, 1'b0, 1'b0);
        send_byte(8'h04, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_tlv(INT_TAG, 1'b0, 0, 0, 0);          // empty INTEGER
        send_tlv(INT_TAG, 1'b0, 5, 1, 0);          // INTEGER too long
        send_tlv(INT_TAG, 1'b1, 3, 0, 0);          // descended INTEGER
        send_byte(8'hA0, 1'b1, 1'b0);              // 0x80 means length zero
        send_byte(8'h80, 1'b0, 1'b0);
        send_tlv(8'hFF, 1'b0, 127, 0, 0);          // largest short form
        send_tlv(8'hA3, 1'b0, 130, 4, 0);
        send_tlv(8'hA1, 1'b1, 0, 0, 0);
        send_tlv(8'hA2, 1'b1, 32'h7FFF_FFFF, 4, 0);
        send_tlv(8'hA4, 1'b1, 5, 127, 0);          // widest long form
        send_byte(8'h00, 1'b0, 1'b0);              // nonzero extra length octet
        send_byte(8'h86, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(8'h30, 1'b0, 1'b1);              // lone tag with last_byte
        send_byte(8'h04, 1'b1, 1'b0);              // entered with last_byte at end
        send_byte(8'h03, 1'b0, 1'b1);
        wait_drained();

        // Random TLVs in three idling phases, with the pressure cases in between.
        k = 0;
        while (bytes_sent < 1040) begin
            if (k == 40) begin
                sender_idle_pct = 46;
                receiver_idle_pct = 16;
            end else if (k == 80) begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
                hold_off_cycles = 300;
            end else if (k == 100) begin
                wait_drained();
            end
            if ($urandom_range(19) == 0) begin
                send_byte(8'($urandom), 1'($urandom), 1'($urandom));
            end else begin
                random_tlv();
            end
            k++;
        end
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire

### ber_tlv_stream_scanner_top.f
src/btss_pkg.sv
src/btss_front.sv
src/btss_queue.sv
src/ber_tlv_stream_scanner_top.sv
sim/testbench.sv
